/* src/phtx_pkg.sv */
// Shared types and protocol constants for the packet header tuple extractor.
package phtx_pkg;

  // Layer-3 classification codes
  localparam logic [2:0] L3_IPV4  = 3'd0;
  localparam logic [2:0] L3_IPV6  = 3'd1;
  localparam logic [2:0] L3_ARP   = 3'd2;
  localparam logic [2:0] L3_RARP  = 3'd3;
  localparam logic [2:0] L3_OTHER = 3'd4;

  // Layer-4 classification codes
  localparam logic [1:0] L4_NONE = 2'd0;
  localparam logic [1:0] L4_TCP  = 2'd1;
  localparam logic [1:0] L4_UDP  = 2'd2;

  // EtherType and protocol numbers
  localparam logic [15:0] TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] TYPE_IPV6 = 16'h86DD;
  localparam logic [15:0] TYPE_ARP  = 16'h0806;
  localparam logic [15:0] TYPE_RARP = 16'h8035;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;

  // Header geometry
  localparam int ETH_HDR_BYTES = 14;
  localparam int IP6_HDR_BYTES = 40;
  localparam int IP4_MIN_END   = 34;
  localparam int IP6_END       = 54;
  localparam int L4_PORT_BYTES = 4;
  // Offset of the layer-4 header never exceeds 14 + 60
  localparam int L4_W = 7;

  // One result word
  typedef struct packed {
    logic [2:0]  l3_kind;
    logic [15:0] ethertype;
    logic [1:0]  l4_kind;
    logic [7:0]  protocol;
    logic [5:0]  ip_header_bytes;
    logic [63:0] src_addr_hi;
    logic [63:0] src_addr_lo;
    logic [63:0] dst_addr_hi;
    logic [63:0] dst_addr_lo;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic        truncated;
  } phtx_result_t;

endpackage

/* src/phtx_core.sv */
// Per-frame header field capture and end-of-frame result formation.
module phtx_core #(
  parameter int MAX_FRAME_BYTES = 65535
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  output phtx_pkg::phtx_result_t result
);

  localparam int OFF_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int L4_W  = phtx_pkg::L4_W;

  logic [OFF_W-1:0] byte_offset, byte_offset_next;
  logic [15:0]      type_reg, type_next, type_shift;
  logic [5:0]       ihl_bytes, ihl_next;
  logic [7:0]       proto_reg, proto_next;
  logic [63:0]      src_high_reg, src_high_next;
  logic [63:0]      src_low_reg, src_low_next;
  logic [63:0]      dst_high_reg, dst_high_next;
  logic [63:0]      dst_low_reg, dst_low_next;
  logic [15:0]      sport_reg, sport_next;
  logic [15:0]      dport_reg, dport_next;
  logic [L4_W-1:0]  l4_start, l4_next;

  logic             in_range, is_v4, is_v6, port_hit;
  logic [OFF_W-1:0] pos, l4_pos, l4_diff;
  logic [OFF_W-1:0] count, cnt_diff;
  logic             short_l4;
  logic [1:0]       got;

  assign pos        = byte_offset;
  assign in_range   = byte_offset != OFF_W'(MAX_FRAME_BYTES);
  assign is_v4      = type_reg == phtx_pkg::TYPE_IPV4;
  assign is_v6      = type_reg == phtx_pkg::TYPE_IPV6;
  assign type_shift = {type_reg[7:0], data_byte};

  // Field capture selected by byte position
  always_comb begin
    byte_offset_next = byte_offset;
    type_next        = type_reg;
    ihl_next         = ihl_bytes;
    proto_next       = proto_reg;
    src_high_next    = src_high_reg;
    src_low_next     = src_low_reg;
    dst_high_next    = dst_high_reg;
    dst_low_next     = dst_low_reg;
    sport_next       = sport_reg;
    dport_next       = dport_reg;
    l4_next          = l4_start;
    if (in_range) begin
      byte_offset_next = pos + OFF_W'(1);
      if (pos == OFF_W'(12) || pos == OFF_W'(13)) begin
        type_next = type_shift;
      end
      if (pos == OFF_W'(13) && type_shift == phtx_pkg::TYPE_IPV6) begin
        l4_next = L4_W'(phtx_pkg::IP6_END);
      end
      if (pos >= OFF_W'(phtx_pkg::ETH_HDR_BYTES)) begin
        if (is_v4) begin
          if (pos == OFF_W'(14)) begin
            ihl_next = {data_byte[3:0], 2'b00};
            l4_next  = L4_W'(phtx_pkg::ETH_HDR_BYTES) + L4_W'({data_byte[3:0], 2'b00});
          end
          if (pos == OFF_W'(23)) proto_next = data_byte;
          if (pos >= OFF_W'(26) && pos <= OFF_W'(29)) begin
            src_low_next = {32'd0, src_low_reg[23:0], data_byte};
          end
          if (pos >= OFF_W'(30) && pos <= OFF_W'(33)) begin
            dst_low_next = {32'd0, dst_low_reg[23:0], data_byte};
          end
        end else if (is_v6) begin
          if (pos == OFF_W'(20)) proto_next = data_byte;
          if (pos >= OFF_W'(22) && pos <= OFF_W'(29)) begin
            src_high_next = {src_high_reg[55:0], data_byte};
          end
          if (pos >= OFF_W'(30) && pos <= OFF_W'(37)) begin
            src_low_next = {src_low_reg[55:0], data_byte};
          end
          if (pos >= OFF_W'(38) && pos <= OFF_W'(45)) begin
            dst_high_next = {dst_high_reg[55:0], data_byte};
          end
          if (pos >= OFF_W'(46) && pos <= OFF_W'(53)) begin
            dst_low_next = {dst_low_reg[55:0], data_byte};
          end
        end
      end
    end
    // Port bytes: first two are the source, next two the destination
    l4_pos   = OFF_W'(l4_next);
    l4_diff  = pos - l4_pos;
    port_hit = in_range && pos >= OFF_W'(phtx_pkg::ETH_HDR_BYTES) && (is_v4 || is_v6) &&
               l4_next != '0 && pos >= l4_pos && l4_diff < OFF_W'(phtx_pkg::L4_PORT_BYTES);
    if (port_hit) begin
      if (!l4_diff[1]) begin
        sport_next = {sport_reg[7:0], data_byte};
      end else begin
        dport_next = {dport_reg[7:0], data_byte};
      end
    end
  end

  // Result built from the state as it stands after this byte
  always_comb begin
    result   = '0;
    result.l3_kind = phtx_pkg::L3_OTHER;
    count    = byte_offset_next;
    cnt_diff = count - OFF_W'(l4_next);
    short_l4 = count < (OFF_W'(l4_next) + OFF_W'(phtx_pkg::L4_PORT_BYTES));
    got      = (count > OFF_W'(l4_next)) ? cnt_diff[1:0] : 2'd0;
    if (count < OFF_W'(phtx_pkg::ETH_HDR_BYTES)) begin
      result.truncated = 1'b1;
    end else begin
      result.ethertype = type_next;
      if (type_next == phtx_pkg::TYPE_ARP) begin
        result.l3_kind = phtx_pkg::L3_ARP;
      end else if (type_next == phtx_pkg::TYPE_RARP) begin
        result.l3_kind = phtx_pkg::L3_RARP;
      end else if (type_next == phtx_pkg::TYPE_IPV4 || type_next == phtx_pkg::TYPE_IPV6) begin
        result.protocol    = proto_next;
        result.src_addr_hi = src_high_next;
        result.src_addr_lo = src_low_next;
        result.dst_addr_hi = dst_high_next;
        result.dst_addr_lo = dst_low_next;
        if (type_next == phtx_pkg::TYPE_IPV4) begin
          result.l3_kind = phtx_pkg::L3_IPV4;
          if (count > OFF_W'(phtx_pkg::ETH_HDR_BYTES)) result.ip_header_bytes = ihl_next;
        end else begin
          result.l3_kind         = phtx_pkg::L3_IPV6;
          result.ip_header_bytes = 6'(phtx_pkg::IP6_HDR_BYTES);
        end
        if ((type_next == phtx_pkg::TYPE_IPV4 && count < OFF_W'(phtx_pkg::IP4_MIN_END)) ||
            (type_next == phtx_pkg::TYPE_IPV6 && count < OFF_W'(phtx_pkg::IP6_END))) begin
          result.truncated = 1'b1;
        end else if (proto_next == phtx_pkg::PROTO_TCP || proto_next == phtx_pkg::PROTO_UDP) begin
          result.l4_kind  = (proto_next == phtx_pkg::PROTO_TCP) ? phtx_pkg::L4_TCP
                                                                : phtx_pkg::L4_UDP;
          result.src_port = sport_next;
          result.dst_port = dport_next;
          if (short_l4) begin
            // left-align what arrived, missing bytes read as zero
            result.truncated = 1'b1;
            case (got)
              2'd0: begin
                result.src_port = '0;
                result.dst_port = '0;
              end
              2'd1: begin
                result.src_port = {sport_next[7:0], 8'd0};
                result.dst_port = '0;
              end
              2'd2: result.dst_port = '0;
              default: result.dst_port = {dport_next[7:0], 8'd0};
            endcase
          end
        end
      end
    end
  end

  // Frame state: cleared by reset and after each final byte
  always_ff @(posedge clk) begin
    if (rst || (take && last_byte)) begin
      byte_offset  <= '0;
      type_reg     <= '0;
      ihl_bytes    <= '0;
      proto_reg    <= '0;
      src_high_reg <= '0;
      src_low_reg  <= '0;
      dst_high_reg <= '0;
      dst_low_reg  <= '0;
      sport_reg    <= '0;
      dport_reg    <= '0;
      l4_start     <= '0;
    end else if (take) begin
      byte_offset  <= byte_offset_next;
      type_reg     <= type_next;
      ihl_bytes    <= ihl_next;
      proto_reg    <= proto_next;
      src_high_reg <= src_high_next;
      src_low_reg  <= src_low_next;
      dst_high_reg <= dst_high_next;
      dst_low_reg  <= dst_low_next;
      sport_reg    <= sport_next;
      dport_reg    <= dport_next;
      l4_start     <= l4_next;
    end
  end

endmodule

/* src/packet_header_tuple_extractor.sv */
// Top level: input word register, header capture core and result register.
// Throughput: one frame byte per cycle, except while a final byte waits for the result register;
// a non-final byte in the input register is never held up by the output. The final byte passes
// the input register, then the result register, before its result is presented.
// A final byte waits in the input register only while an earlier result is not taken.
// Reset: synchronous; clears frame state and both valid flags, no result pending.
module packet_header_tuple_extractor #(
  parameter int MAX_FRAME_BYTES = 65535
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  l3_kind,
  output logic [15:0] ethertype,
  output logic [1:0]  l4_kind,
  output logic [7:0]  protocol,
  output logic [5:0]  ip_header_bytes,
  output logic [63:0] src_addr_hi,
  output logic [63:0] src_addr_lo,
  output logic [63:0] dst_addr_hi,
  output logic [63:0] dst_addr_lo,
  output logic [15:0] src_port,
  output logic [15:0] dst_port,
  output logic        truncated
);

  logic                   s1_valid, s1_last, s1_go;
  logic [7:0]             s1_data;
  phtx_pkg::phtx_result_t core_result, out_word;

  // Input word advances unless it is a final byte facing a full result register
  assign s1_go    = s1_valid && (!s1_last || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data <= data_byte;
      s1_last <= last_byte;
    end
  end

  phtx_core #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (s1_go),
    .data_byte (s1_data),
    .last_byte (s1_last),
    .result    (core_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      out_word <= core_result;
    end
  end

  assign l3_kind         = out_word.l3_kind;
  assign ethertype       = out_word.ethertype;
  assign l4_kind         = out_word.l4_kind;
  assign protocol        = out_word.protocol;
  assign ip_header_bytes = out_word.ip_header_bytes;
  assign src_addr_hi     = out_word.src_addr_hi;
  assign src_addr_lo     = out_word.src_addr_lo;
  assign dst_addr_hi     = out_word.dst_addr_hi;
  assign dst_addr_lo     = out_word.dst_addr_lo;
  assign src_port        = out_word.src_port;
  assign dst_port        = out_word.dst_port;
  assign truncated       = out_word.truncated;

endmodule

/* test/packet_header_tuple_extractor_tb.sv */
// Testbench for the packet header tuple extractor: directed and random frames, scoreboarded.
`timescale 1ns / 100ps

module packet_header_tuple_extractor_tb;

  // Small frame limit so the drop-past-limit path is reachable in a short run
  localparam int MAX_BYTES    = 80;
  localparam int LIMIT_CYCLES = 50000;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  l3_kind;
  logic [15:0] ethertype;
  logic [1:0]  l4_kind;
  logic [7:0]  protocol;
  logic [5:0]  ip_header_bytes;
  logic [63:0] src_addr_hi;
  logic [63:0] src_addr_lo;
  logic [63:0] dst_addr_hi;
  logic [63:0] dst_addr_lo;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic        truncated;

  // Header capture state of the frame in progress
  int          frame_pos = 0;
  logic [15:0] eth_type = '0;
  logic [5:0]  hdr_len = '0;
  logic [7:0]  proto_r = '0;
  logic [63:0] src_hi = '0, src_lo = '0, dst_hi = '0, dst_lo = '0;
  logic [15:0] sport = '0, dport = '0;
  int          l4_off = 0;

  phtx_pkg::phtx_result_t tuple_q[$];
  int errors = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;

  packet_header_tuple_extractor #(.MAX_FRAME_BYTES(MAX_BYTES)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .l3_kind(l3_kind), .ethertype(ethertype), .l4_kind(l4_kind), .protocol(protocol),
    .ip_header_bytes(ip_header_bytes),
    .src_addr_hi(src_addr_hi), .src_addr_lo(src_addr_lo),
    .dst_addr_hi(dst_addr_hi), .dst_addr_lo(dst_addr_lo),
    .src_port(src_port), .dst_port(dst_port), .truncated(truncated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("%0t: timeout, %0d tuples outstanding", $time, tuple_q.size());
      $display("[packet_header_tuple_extractor] ERROR");
      $finish;
    end
  end

  // Result side back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic void clear_frame();
    frame_pos = 0;
    eth_type = '0;
    hdr_len = '0;
    proto_r = '0;
    src_hi = '0;
    src_lo = '0;
    dst_hi = '0;
    dst_lo = '0;
    sport = '0;
    dport = '0;
    l4_off = 0;
  endfunction

  // Store one frame byte into whichever header field its position selects
  function automatic void capture_byte(int pos, logic [7:0] b);
    if (pos == 12 || pos == 13) eth_type = {eth_type[7:0], b};
    if (pos == 13 && eth_type == phtx_pkg::TYPE_IPV6) begin
      l4_off = phtx_pkg::ETH_HDR_BYTES + phtx_pkg::IP6_HDR_BYTES;
    end
    if (pos < phtx_pkg::ETH_HDR_BYTES) return;
    if (eth_type == phtx_pkg::TYPE_IPV4) begin
      if (pos == 14) begin
        hdr_len = {b[3:0], 2'b00};
        l4_off = phtx_pkg::ETH_HDR_BYTES + hdr_len;
      end
      if (pos == 23) proto_r = b;
      if (pos >= 26 && pos <= 29) src_lo = {32'd0, src_lo[23:0], b};
      if (pos >= 30 && pos <= 33) dst_lo = {32'd0, dst_lo[23:0], b};
    end else if (eth_type == phtx_pkg::TYPE_IPV6) begin
      if (pos == 20) proto_r = b;
      if (pos >= 22 && pos <= 29) src_hi = {src_hi[55:0], b};
      if (pos >= 30 && pos <= 37) src_lo = {src_lo[55:0], b};
      if (pos >= 38 && pos <= 45) dst_hi = {dst_hi[55:0], b};
      if (pos >= 46 && pos <= 53) dst_lo = {dst_lo[55:0], b};
    end else begin
      return;
    end
    // Ports; with a tiny IHL these overlap IPv4 header bytes
    if (l4_off != 0 && pos >= l4_off && pos < l4_off + phtx_pkg::L4_PORT_BYTES) begin
      if (pos < l4_off + 2) sport = {sport[7:0], b};
      else dport = {dport[7:0], b};
    end
  endfunction

  // Track one accepted word; on the final byte queue the expected tuple
  function automatic void predict_tuple(logic [7:0] b, logic lst);
    phtx_pkg::phtx_result_t r;
    int count;
    int l3_end;
    int got;
    bit is_ip;
    if (frame_pos < MAX_BYTES) begin
      capture_byte(frame_pos, b);
      frame_pos++;
    end
    if (!lst) return;
    r = '0;
    r.l3_kind = phtx_pkg::L3_OTHER;
    is_ip = 1'b0;
    l3_end = 0;
    count = frame_pos;
    if (count < phtx_pkg::ETH_HDR_BYTES) begin
      r.truncated = 1'b1;
    end else begin
      r.ethertype = eth_type;
      case (eth_type)
        phtx_pkg::TYPE_IPV4: begin
          r.l3_kind = phtx_pkg::L3_IPV4;
          is_ip = 1'b1;
          l3_end = phtx_pkg::IP4_MIN_END;
          if (count > phtx_pkg::ETH_HDR_BYTES) r.ip_header_bytes = hdr_len;
        end
        phtx_pkg::TYPE_IPV6: begin
          r.l3_kind = phtx_pkg::L3_IPV6;
          is_ip = 1'b1;
          l3_end = phtx_pkg::IP6_END;
          r.ip_header_bytes = 6'(phtx_pkg::IP6_HDR_BYTES);
        end
        phtx_pkg::TYPE_ARP:  r.l3_kind = phtx_pkg::L3_ARP;
        phtx_pkg::TYPE_RARP: r.l3_kind = phtx_pkg::L3_RARP;
        default: ;
      endcase
    end
    if (is_ip) begin
      r.protocol = proto_r;
      r.src_addr_hi = src_hi;
      r.src_addr_lo = src_lo;
      r.dst_addr_hi = dst_hi;
      r.dst_addr_lo = dst_lo;
      if (count < l3_end) begin
        r.truncated = 1'b1;
      end else if (proto_r == phtx_pkg::PROTO_TCP || proto_r == phtx_pkg::PROTO_UDP) begin
        r.l4_kind = (proto_r == phtx_pkg::PROTO_TCP) ? phtx_pkg::L4_TCP : phtx_pkg::L4_UDP;
        r.src_port = sport;
        r.dst_port = dport;
        if (count < l4_off + phtx_pkg::L4_PORT_BYTES) begin
          // missing port bytes read as zero, received ones left-aligned
          got = (count > l4_off) ? count - l4_off : 0;
          r.truncated = 1'b1;
          case (got)
            0: begin
              r.src_port = '0;
              r.dst_port = '0;
            end
            1: begin
              r.src_port = {sport[7:0], 8'h00};
              r.dst_port = '0;
            end
            2: r.dst_port = '0;
            default: r.dst_port = {dport[7:0], 8'h00};
          endcase
        end
      end
    end
    tuple_q.insert(tuple_q.size(), r);
    clear_frame();
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // Result checker
  always @(posedge clk) begin
    phtx_pkg::phtx_result_t w;
    if (!rst && out_valid && out_ready) begin
      if (tuple_q.size() == 0) begin
        errors++;
        $display("%0t: result with no frame pending, expected none, actual l3 %0d type %h",
                 $time, l3_kind, ethertype);
      end else begin
        w = tuple_q.pop_front();
        check_field("l3_kind", w.l3_kind, l3_kind);
        check_field("ethertype", w.ethertype, ethertype);
        check_field("l4_kind", w.l4_kind, l4_kind);
        check_field("protocol", w.protocol, protocol);
        check_field("ip_header_bytes", w.ip_header_bytes, ip_header_bytes);
        check_field("src_addr_hi", w.src_addr_hi, src_addr_hi);
        check_field("src_addr_lo", w.src_addr_lo, src_addr_lo);
        check_field("dst_addr_hi", w.dst_addr_hi, dst_addr_hi);
        check_field("dst_addr_lo", w.dst_addr_lo, dst_addr_lo);
        check_field("src_port", w.src_port, src_port);
        check_field("dst_port", w.dst_port, dst_port);
        check_field("truncated", w.truncated, truncated);
      end
    end
  end

  // Send one word; valid stays up into the next word unless an idle gap is drawn
  task automatic send_byte(logic [7:0] b, logic lst);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    last_byte <= lst;
    do @(posedge clk); while (!in_ready);
    predict_tuple(b, lst);
    bytes_sent++;
  endtask

  task automatic send_frame(ref logic [7:0] f[$]);
    for (int i = 0; i < f.size(); i++) send_byte(f[i], i == f.size() - 1);
    frames_sent++;
  endtask

  // Hold off the sender until every queued tuple has come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tuple_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Frame of len bytes; fill < 0 means random payload
  function automatic void make_frame(ref logic [7:0] f[$], input logic [15:0] etype,
                                     input logic [3:0] ihl, input logic [7:0] prot,
                                     input int len, input int fill);
    logic [7:0] v;
    f.delete();
    for (int i = 0; i < len; i++) begin
      v = (fill < 0) ? 8'($urandom) : 8'(fill);
      if (i == 12) v = etype[15:8];
      if (i == 13) v = etype[7:0];
      if (etype == phtx_pkg::TYPE_IPV4 && i == 14) v = {v[7:4], ihl};
      if (etype == phtx_pkg::TYPE_IPV4 && i == 23) v = prot;
      if (etype == phtx_pkg::TYPE_IPV6 && i == 20) v = prot;
      f.insert(f.size(), v);
    end
  endfunction

  // Frame length that just covers both ports of an IP frame; the Ethernet header alone otherwise
  function automatic int tuple_end(logic [15:0] etype, logic [3:0] ihl);
    if (etype == phtx_pkg::TYPE_IPV4) begin
      return phtx_pkg::ETH_HDR_BYTES + 4 * ihl + phtx_pkg::L4_PORT_BYTES;
    end
    if (etype == phtx_pkg::TYPE_IPV6) return phtx_pkg::IP6_END + phtx_pkg::L4_PORT_BYTES;
    return phtx_pkg::ETH_HDR_BYTES;
  endfunction

  task automatic test_short_frames();
    logic [7:0] f[$];
    make_frame(f, phtx_pkg::TYPE_IPV4, 4'd5, phtx_pkg::PROTO_TCP, 1, -1);
    send_frame(f);
    make_frame(f, phtx_pkg::TYPE_IPV4, 4'd5, phtx_pkg::PROTO_TCP, 13, -1);
    send_frame(f);
    make_frame(f, phtx_pkg::TYPE_IPV4, 4'd5, phtx_pkg::PROTO_TCP, 14, -1);
    send_frame(f);
    make_frame(f, phtx_pkg::TYPE_IPV4, 4'd5, phtx_pkg::PROTO_TCP, 28, -1);
    send_frame(f);
    make_frame(f, phtx_pkg::TYPE_IPV4, 4'd5, phtx_pkg::PROTO_UDP, 33, -1);
    send_frame(f);
    make_frame(f, phtx_pkg::TYPE_IPV6, 4'd0, phtx_pkg::PROTO_TCP, 40, -1);
    send_frame(f);
    make_frame(f, phtx_pkg::TYPE_IPV6, 4'd0, phtx_pkg::PROTO_UDP, 53, -1);
    send_frame(f);
  endtask

  task automatic test_ipv4();
    logic [7:0] f[$];
    // all ones, version nibble not 4
    make_frame(f, phtx_pkg::TYPE_IPV4, 4'd5, phtx_pkg::PROTO_TCP, 38, 255);
    send_frame(f);
    make_frame(f, phtx_pkg::TYPE_IPV4, 4'd5, phtx_pkg::PROTO_UDP, 60, 0);
    send_frame(f);
    make_frame(f, phtx_pkg::TYPE_IPV4, 4'd15, phtx_pkg::PROTO_UDP, 78, -1);
    send_frame(f);
    make_frame(f, phtx_pkg::TYPE_IPV4, 4'd5, 8'd1, 60, -1);
    send_frame(f);
    // header length below the minimum: ports overlap the IP header
    make_frame(f, phtx_pkg::TYPE_IPV4, 4'd0, phtx_pkg::PROTO_TCP, 40, -1);
    send_frame(f);
    make_frame(f, phtx_pkg::TYPE_IPV4, 4'd3, phtx_pkg::PROTO_UDP, 40, -1);
    send_frame(f);
    // frame ends inside the ports
    make_frame(f, phtx_pkg::TYPE_IPV4, 4'd5, phtx_pkg::PROTO_TCP, 35, -1);
    send_frame(f);
    make_frame(f, phtx_pkg::TYPE_IPV4, 4'd5, phtx_pkg::PROTO_TCP, 37, -1);
    send_frame(f);
  endtask

  task automatic test_ipv6();
    logic [7:0] f[$];
    make_frame(f, phtx_pkg::TYPE_IPV6, 4'd0, phtx_pkg::PROTO_TCP, 70, -1);
    send_frame(f);
    make_frame(f, phtx_pkg::TYPE_IPV6, 4'd0, phtx_pkg::PROTO_UDP, 58, 255);
    send_frame(f);
    make_frame(f, phtx_pkg::TYPE_IPV6, 4'd0, phtx_pkg::PROTO_TCP, 56, -1);
    send_frame(f);
    make_frame(f, phtx_pkg::TYPE_IPV6, 4'd0, 8'd59, 60, -1);
    send_frame(f);
  endtask

  task automatic test_non_ip();
    logic [7:0] f[$];
    make_frame(f, phtx_pkg::TYPE_ARP, 4'd0, 8'd0, 42, -1);
    send_frame(f);
    make_frame(f, phtx_pkg::TYPE_RARP, 4'd0, 8'd0, 60, -1);
    send_frame(f);
    make_frame(f, 16'hFFFF, 4'd0, 8'd0, 60, 255);
    send_frame(f);
    make_frame(f, 16'h0000, 4'd0, 8'd0, 64, 0);
    send_frame(f);
    make_frame(f, phtx_pkg::TYPE_IPV6 ^ 16'h0001, 4'd0, phtx_pkg::PROTO_TCP, 60, -1);
    send_frame(f);
  endtask

  // Bytes past the frame limit must be dropped, not wrap onto the header
  task automatic test_long_frame();
    logic [7:0] f[$];
    make_frame(f, phtx_pkg::TYPE_IPV4, 4'd5, phtx_pkg::PROTO_UDP, MAX_BYTES + 25, -1);
    send_frame(f);
    // maximum header length: ports still end inside the limit
    make_frame(f, phtx_pkg::TYPE_IPV4, 4'd15, phtx_pkg::PROTO_TCP, MAX_BYTES + 10, -1);
    send_frame(f);
  endtask

  // Mostly well-formed frames with random content, some broken or foreign
  task automatic test_random(int idle, int stall);
    logic [7:0]  f[$];
    logic [15:0] etype;
    logic [3:0]  ihl;
    logic [7:0]  prot;
    int len, full, pick, start_bytes, start_frames;
    idle_pct = idle;
    stall_pct = stall;
    start_bytes = bytes_sent;
    start_frames = frames_sent;
    while (bytes_sent - start_bytes < 160 || frames_sent - start_frames < 3) begin
      pick = $urandom_range(99);
      if (pick < 40) etype = phtx_pkg::TYPE_IPV4;
      else if (pick < 65) etype = phtx_pkg::TYPE_IPV6;
      else if (pick < 72) etype = phtx_pkg::TYPE_ARP;
      else if (pick < 79) etype = phtx_pkg::TYPE_RARP;
      else if (pick < 89) etype = 16'($urandom);
      else etype = phtx_pkg::TYPE_IPV4 ^ (16'd1 << $urandom_range(15));
      pick = $urandom_range(99);
      if (pick < 40) prot = phtx_pkg::PROTO_TCP;
      else if (pick < 75) prot = phtx_pkg::PROTO_UDP;
      else prot = 8'($urandom);
      ihl = ($urandom_range(9) < 7) ? 4'd5 : 4'($urandom);
      full = tuple_end(etype, ihl);
      if ($urandom_range(9) < 7) len = full + $urandom_range(12);
      else len = $urandom_range(full, 1);
      make_frame(f, etype, ihl, prot, len, -1);
      send_frame(f);
    end
    wait_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_short_frames();
    test_ipv4();
    test_ipv6();
    test_non_ip();
    wait_idle();
    test_long_frame();
    wait_idle();
    test_random(0, 0);
    test_random(61, 0);
    test_random(0, 61);
    test_random(20, 20);

    wait_idle();
    repeat (10) @(posedge clk);
    if (tuple_q.size() != 0) begin
      errors++;
      $display("%0t: %0d expected tuples never arrived", $time, tuple_q.size());
    end
    if (errors == 0) begin
      $display("[packet_header_tuple_extractor] OK");
    end else begin
      $display("[packet_header_tuple_extractor] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/phtx_pkg.sv
src/phtx_core.sv
src/packet_header_tuple_extractor.sv
test/packet_header_tuple_extractor_tb.sv
